// ----- src/id3_pkg.sv -----
package id3_pkg;

    localparam int unsigned HDR_BYTES = 10;
    localparam int unsigned SYNCSAFE_FIRST = 6;
    localparam int unsigned ID_BYTES = 4;
    localparam int unsigned SIZE_END = 8;
    localparam int unsigned RES_DEPTH = 4;

    typedef enum logic [1:0] {
        PH_TAG     = 2'd0,
        PH_FRAME   = 2'd1,
        PH_PAYLOAD = 2'd2,
        PH_DONE    = 2'd3
    } phase_t;

    localparam logic [2:0] KIND_TITLE   = 3'd0;
    localparam logic [2:0] KIND_ARTIST  = 3'd1;
    localparam logic [2:0] KIND_ALBUM   = 3'd2;
    localparam logic [2:0] KIND_YEAR    = 3'd3;
    localparam logic [2:0] KIND_CONTENT = 3'd4;
    localparam logic [2:0] KIND_COMMENT = 3'd5;
    localparam logic [2:0] KIND_NONE    = 3'd7;

    localparam logic [31:0] ID_TIT2 = 32'h5449_5432;
    localparam logic [31:0] ID_TPE1 = 32'h5450_4531;
    localparam logic [31:0] ID_TALB = 32'h5441_4C42;
    localparam logic [31:0] ID_TYER = 32'h5459_4552;
    localparam logic [31:0] ID_TCON = 32'h5443_4F4E;
    localparam logic [31:0] ID_COMM = 32'h434F_4D4D;

    typedef struct packed {
        logic       last;
        logic       bvalid;
        logic [7:0] text;
        logic [2:0] kind;
    } res_t;

    function automatic logic [2:0] id3_lookup(input logic [31:0] id);
        logic [2:0] k;
        k = KIND_NONE;
        case (id)
            ID_TIT2: k = KIND_TITLE;
            ID_TPE1: k = KIND_ARTIST;
            ID_TALB: k = KIND_ALBUM;
            ID_TYER: k = KIND_YEAR;
            ID_TCON: k = KIND_CONTENT;
            ID_COMM: k = KIND_COMMENT;
            default: k = KIND_NONE;
        endcase
        return k;
    endfunction

endpackage

// ----- src/id3v2_text_frame_parser.sv -----
// ID3v2 text frame parser. Takes a file one byte per transfer (tuser high on
// byte 0 restarts the parser), skips the 10-byte tag header while keeping its
// syncsafe 28-bit size, then walks frames (4-byte ID, 4-byte big-endian size,
// 2 flag bytes, payload). For TIT2, TPE1, TALB, TYER, TCON and COMM it drops
// the encoding byte and streams the text bytes up to the first zero or the
// payload end, then one end marker (tlast high, byte-valid flag low). Bytes
// past the tag are swallowed. Rate: one byte per cycle; each byte is held in
// the input register, where the parser state is updated, and its results
// (zero, one or two) go to a small result queue. The queue drains one result
// per cycle while m_axis_tready is high, and a byte that yields two results
// (last text byte plus end marker) needs an output transfer for each; input
// stalls only while the queue has fewer than two free slots.
module id3v2_text_frame_parser #(
    parameter int unsigned RES_DEPTH = id3_pkg::RES_DEPTH  // result queue, >= 2
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // [7:0] file_byte
    input  logic       s_axis_tuser,   // [0] first_byte
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,   // [7:0] text_byte
    output logic [3:0] m_axis_tuser,   // [2:0] frame_kind, [3] byte_valid
    output logic       m_axis_tlast    // end_of_text
);
    import id3_pkg::*;

    // input register stage
    logic       in_valid_reg, in_valid_next;
    logic [7:0] in_byte_reg;
    logic       in_first_reg;

    logic       step;
    logic       room2;
    logic [1:0] res_n;
    res_t       res0;
    res_t       res1;
    res_t       out_res;

    // a held byte moves on once the queue can take its worst-case two results
    assign step          = in_valid_reg && room2;
    assign s_axis_tready = !in_valid_reg || step;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (s_axis_tvalid && s_axis_tready)
            in_valid_next = 1'b1;
        else if (step)
            in_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else
            in_valid_reg <= in_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            in_byte_reg  <= s_axis_tdata;
            in_first_reg <= s_axis_tuser;
        end
    end

    id3_parse_core u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .step       (step),
        .file_byte  (in_byte_reg),
        .first_byte (in_first_reg),
        .res_n      (res_n),
        .res0       (res0),
        .res1       (res1)
    );

    id3_res_fifo #(
        .DEPTH (RES_DEPTH)
    ) u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push_n    (res_n),
        .push0     (res0),
        .push1     (res1),
        .room2     (room2),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_res   (out_res)
    );

    assign m_axis_tdata = out_res.text;
    assign m_axis_tuser = {out_res.bvalid, out_res.kind};
    assign m_axis_tlast = out_res.last;

endmodule

// ----- src/id3_res_fifo.sv -----
module id3_res_fifo #(
    parameter int unsigned DEPTH = id3_pkg::RES_DEPTH
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic [1:0]    push_n,
    input  id3_pkg::res_t push0,
    input  id3_pkg::res_t push1,
    output logic          room2,
    output logic          out_valid,
    input  logic          out_ready,
    output id3_pkg::res_t out_res
);
    import id3_pkg::*;

    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);

    res_t          mem_reg [DEPTH];
    logic [AW-1:0] head_reg, head_next;
    logic [AW-1:0] tail_reg, tail_next;
    logic [CW-1:0] count_reg, count_next;
    logic [AW-1:0] tail_p1;
    logic [AW-1:0] tail_p2;
    logic          pop;

    function automatic logic [AW-1:0] inc(input logic [AW-1:0] p);
        return (p == AW'(DEPTH - 1)) ? '0 : p + AW'(1);
    endfunction

    assign pop       = out_valid && out_ready;
    assign out_valid = (count_reg != '0);
    assign out_res   = mem_reg[head_reg];
    assign room2     = (count_reg <= CW'(DEPTH - 2));
    assign tail_p1   = inc(tail_reg);
    assign tail_p2   = inc(tail_p1);

    always_comb
    begin
        head_next  = pop ? inc(head_reg) : head_reg;
        case (push_n)
            2'd1:    tail_next = tail_p1;
            2'd2:    tail_next = tail_p2;
            default: tail_next = tail_reg;
        endcase
        count_next = count_reg + CW'(push_n) - CW'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
        end
    end

    // payload storage, no reset
    always_ff @(posedge clk)
    begin
        if (push_n != 2'd0)
            mem_reg[tail_reg] <= push0;
        if (push_n == 2'd2)
            mem_reg[tail_p1] <= push1;
    end

endmodule

// ----- src/id3_parse_core.sv -----
module id3_parse_core (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          step,
    input  logic [7:0]    file_byte,
    input  logic          first_byte,
    output logic [1:0]    res_n,
    output id3_pkg::res_t res0,
    output id3_pkg::res_t res1
);
    import id3_pkg::*;

    phase_t      phase_reg, phase_next;
    logic [3:0]  fc_reg, fc_next;
    logic [27:0] tag_len_reg, tag_len_next;
    logic [32:0] consumed_reg, consumed_next;
    logic [31:0] fid_reg, fid_next;
    logic [31:0] flen_reg, flen_next;
    logic [31:0] left_reg, left_next;
    logic [2:0]  kind_reg, kind_next;

    // state as seen by this byte (a first byte restarts from reset values)
    phase_t      ph;
    logic [3:0]  fc;
    logic [27:0] tag_len;
    logic [32:0] consumed;
    logic [31:0] fid;
    logic [31:0] flen;
    logic [31:0] left;
    logic [2:0]  kind;

    logic [4:0]  fc_inc;
    logic        hdr_end;
    logic [2:0]  kind_lk;
    logic [32:0] consumed_sum;
    logic        more_frames;
    logic        enc;
    logic        last_pl;
    logic        emit_text;
    logic [2:0]  kind_mid;
    logic [27:0] tag_shift;

    assign ph       = first_byte ? PH_TAG : phase_reg;
    assign fc       = first_byte ? '0 : fc_reg;
    assign tag_len  = first_byte ? '0 : tag_len_reg;
    assign consumed = first_byte ? '0 : consumed_reg;
    assign fid      = first_byte ? '0 : fid_reg;
    assign flen     = first_byte ? '0 : flen_reg;
    assign left     = first_byte ? '0 : left_reg;
    assign kind     = first_byte ? KIND_NONE : kind_reg;

    assign fc_inc       = {1'b0, fc} + 5'd1;
    assign hdr_end      = (fc_inc >= 5'(HDR_BYTES));
    assign kind_lk      = id3_lookup(fid);
    assign consumed_sum = consumed + 33'(HDR_BYTES) + {1'b0, flen};
    assign more_frames  = (consumed_sum < {5'd0, tag_len});
    assign enc          = (left == flen);
    assign last_pl      = (left == 32'd1);
    assign emit_text    = (kind != KIND_NONE) && !enc;
    assign kind_mid     = (emit_text && file_byte == 8'd0) ? KIND_NONE : kind;
    assign tag_shift    = {tag_len[20:0], file_byte[6:0]};

    // next state
    always_comb
    begin
        phase_next    = ph;
        fc_next       = fc;
        tag_len_next  = tag_len;
        consumed_next = consumed;
        fid_next      = fid;
        flen_next     = flen;
        left_next     = left;
        kind_next     = kind;
        case (ph)
            PH_TAG:
            begin
                if (fc >= 4'(SYNCSAFE_FIRST))
                    tag_len_next = tag_shift;
                fc_next = fc_inc[3:0];
                if (hdr_end)
                begin
                    fc_next       = '0;
                    consumed_next = '0;
                    phase_next    = (tag_len_next != '0) ? PH_FRAME : PH_DONE;
                end
            end
            PH_FRAME:
            begin
                if (fc < 4'(ID_BYTES))
                    fid_next = {fid[23:0], file_byte};
                else if (fc < 4'(SIZE_END))
                    flen_next = {flen[23:0], file_byte};
                fc_next = fc_inc[3:0];
                if (hdr_end)
                begin
                    fc_next   = '0;
                    kind_next = kind_lk;
                    left_next = flen;
                    if (flen == '0)
                    begin
                        consumed_next = consumed_sum;
                        kind_next     = KIND_NONE;
                        phase_next    = more_frames ? PH_FRAME : PH_DONE;
                    end
                    else
                        phase_next = PH_PAYLOAD;
                end
            end
            PH_PAYLOAD:
            begin
                left_next = left - 32'd1;
                kind_next = kind_mid;
                if (last_pl)
                begin
                    consumed_next = consumed_sum;
                    kind_next     = KIND_NONE;
                    phase_next    = more_frames ? PH_FRAME : PH_DONE;
                end
            end
            default: ;
        endcase
    end

    // result slots, packed toward slot 0
    always_comb
    begin
        res0  = '0;
        res1  = '0;
        res_n = 2'd0;
        case (ph)
            PH_FRAME:
            begin
                if (hdr_end && flen == '0 && kind_lk != KIND_NONE)
                begin
                    res0  = '{last: 1'b1, bvalid: 1'b0, text: 8'd0, kind: kind_lk};
                    res_n = 2'd1;
                end
            end
            PH_PAYLOAD:
            begin
                if (emit_text)
                begin
                    if (file_byte == 8'd0)
                        res0 = '{last: 1'b1, bvalid: 1'b0, text: 8'd0, kind: kind};
                    else
                        res0 = '{last: 1'b0, bvalid: 1'b1, text: file_byte, kind: kind};
                    if (last_pl && kind_mid != KIND_NONE)
                    begin
                        res1  = '{last: 1'b1, bvalid: 1'b0, text: 8'd0, kind: kind_mid};
                        res_n = 2'd2;
                    end
                    else
                        res_n = 2'd1;
                end
                else if (last_pl && kind != KIND_NONE)
                begin
                    res0  = '{last: 1'b1, bvalid: 1'b0, text: 8'd0, kind: kind};
                    res_n = 2'd1;
                end
            end
            default: ;
        endcase
        if (!step)
            res_n = 2'd0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_TAG;
            fc_reg       <= '0;
            tag_len_reg  <= '0;
            consumed_reg <= '0;
            fid_reg      <= '0;
            flen_reg     <= '0;
            left_reg     <= '0;
            kind_reg     <= KIND_NONE;
        end
        else if (step)
        begin
            phase_reg    <= phase_next;
            fc_reg       <= fc_next;
            tag_len_reg  <= tag_len_next;
            consumed_reg <= consumed_next;
            fid_reg      <= fid_next;
            flen_reg     <= flen_next;
            left_reg     <= left_next;
            kind_reg     <= kind_next;
        end
    end

endmodule

// ----- tb/sv/testbench.sv -----
module testbench;

    import id3_pkg::*;

    localparam int unsigned CYCLE_LIMIT  = 400000;
    localparam int unsigned DRAIN_CYCLES = 24;
    localparam int unsigned RANDOM_GOAL  = 1150;  // walked-byte total that the random files run up to
    localparam int unsigned NOISE_BYTES  = 150;
    localparam int unsigned TAIL_BYTES   = 200;   // walked bytes with no idling at all

    // text frame IDs and the kind each one maps to, index for index
    localparam logic [31:0] TEXT_IDS [6] = '{ID_TIT2, ID_TPE1, ID_TALB,
                                             ID_TYER, ID_TCON, ID_COMM};
    localparam logic [2:0]  TEXT_KINDS [6] = '{KIND_TITLE, KIND_ARTIST, KIND_ALBUM,
                                               KIND_YEAR, KIND_CONTENT, KIND_COMMENT};
    localparam logic [31:0] ID_TXXX = 32'h5458_5858;

    logic       clk = 1'b0;
    logic       rst_n;
    logic       s_axis_tvalid;
    logic       s_axis_tready;
    logic [7:0] s_axis_tdata;     // [7:0] file_byte
    logic       s_axis_tuser;     // [0] first_byte
    logic       m_axis_tvalid;
    logic       m_axis_tready;
    logic [7:0] m_axis_tdata;     // [7:0] text_byte
    logic [3:0] m_axis_tuser;     // [2:0] frame_kind, [3] byte_valid
    logic       m_axis_tlast;     // end_of_text

    id3v2_text_frame_parser dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Parser shadow: walks the same bytes as the block and queues the
    // text transfers it must produce.
    // ------------------------------------------------------------------
    phase_t      walk_phase = PH_TAG;
    logic [3:0]  hdr_count  = '0;
    logic [27:0] tag_len    = '0;
    logic [32:0] used_len   = '0;
    logic [31:0] cur_id     = '0;
    logic [31:0] cur_len    = '0;
    logic [31:0] bytes_left = '0;
    logic [2:0]  cur_kind   = KIND_NONE;

    res_t expected_text_q [$];

    int unsigned mismatches      = 0;
    int unsigned results_checked = 0;
    int unsigned bytes_walked    = 0;
    int unsigned files_sent      = 0;
    int unsigned cycle_count     = 0;

    bit          calm           = 1'b0;  // no idling on either side
    int unsigned send_idle_odds = 0;     // 0: no gaps, else 1 in N bytes gets a gap
    int unsigned recv_idle_odds = 0;

    logic [7:0] file_bytes [$];

    function automatic logic [2:0] kind_of_id(input logic [31:0] id);
        for (int k = 0; k < 6; k++)
            if (TEXT_IDS[k] == id)
                return TEXT_KINDS[k];
        return KIND_NONE;
    endfunction

    function automatic void expect_text(input logic [7:0] ch, input logic bv,
                                        input logic eot);
        res_t r;
        r.kind   = cur_kind;
        r.text   = ch;
        r.bvalid = bv;
        r.last   = eot;
        expected_text_q.push_back(r);
    endfunction

    function automatic void close_frame();
        used_len   = used_len + 33'(HDR_BYTES) + {1'b0, cur_len};
        cur_kind   = KIND_NONE;
        walk_phase = (used_len < {5'd0, tag_len}) ? PH_FRAME : PH_DONE;
    endfunction

    function automatic void predict_text_bytes(input logic [7:0] b, input logic first);
        bit enc;
        if (first)
        begin
            walk_phase = PH_TAG;
            hdr_count  = '0;
            tag_len    = '0;
            used_len   = '0;
            cur_id     = '0;
            cur_len    = '0;
            bytes_left = '0;
            cur_kind   = KIND_NONE;
        end
        case (walk_phase)
            PH_TAG:
            begin
                // syncsafe size: bytes 6..9, seven bits each
                if (hdr_count >= SYNCSAFE_FIRST)
                    tag_len = {tag_len[20:0], b[6:0]};
                hdr_count++;
                if (hdr_count >= HDR_BYTES)
                begin
                    hdr_count  = '0;
                    used_len   = '0;
                    walk_phase = (tag_len != 0) ? PH_FRAME : PH_DONE;
                end
            end
            PH_FRAME:
            begin
                if (hdr_count < ID_BYTES)
                    cur_id = {cur_id[23:0], b};
                else if (hdr_count < SIZE_END)
                    cur_len = {cur_len[23:0], b};
                hdr_count++;
                if (hdr_count >= HDR_BYTES)
                begin
                    hdr_count  = '0;
                    cur_kind   = kind_of_id(cur_id);
                    bytes_left = cur_len;
                    if (cur_len == 0)
                    begin
                        // empty text frame closes on its last flag byte
                        if (cur_kind != KIND_NONE)
                            expect_text(8'h00, 1'b0, 1'b1);
                        close_frame();
                    end
                    else
                        walk_phase = PH_PAYLOAD;
                end
            end
            PH_PAYLOAD:
            begin
                enc = (bytes_left == cur_len);  // first payload byte is the encoding
                bytes_left--;
                if (cur_kind != KIND_NONE && !enc)
                begin
                    if (b == 8'h00)
                    begin
                        expect_text(8'h00, 1'b0, 1'b1);
                        cur_kind = KIND_NONE;
                    end
                    else
                        expect_text(b, 1'b1, 1'b0);
                end
                if (bytes_left == 0)
                begin
                    if (cur_kind != KIND_NONE)
                        expect_text(8'h00, 1'b0, 1'b1);
                    close_frame();
                end
            end
            default: ;
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Mismatch report
    // ------------------------------------------------------------------
    task automatic report_mismatch(input string what);
        $display("[%0t] mismatch: %s", $time, what);
        mismatches++;
    endtask

    // ------------------------------------------------------------------
    // Output side: random stall bursts on tready, check every transfer
    // against the oldest expected text transfer.
    // ------------------------------------------------------------------
    initial
    begin
        int unsigned stall_left;
        res_t        want;
        stall_left    = 0;
        m_axis_tready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && m_axis_tvalid && m_axis_tready)
            begin
                if (expected_text_q.size() == 0)
                    report_mismatch($sformatf("unexpected transfer data=%02h user=%h last=%b",
                                              m_axis_tdata, m_axis_tuser, m_axis_tlast));
                else
                begin
                    want = expected_text_q.pop_front();
                    results_checked++;
                    if (m_axis_tuser[2:0] !== want.kind)
                        report_mismatch($sformatf("frame_kind %0d, want %0d",
                                                  m_axis_tuser[2:0], want.kind));
                    if (m_axis_tdata !== want.text)
                        report_mismatch($sformatf("text_byte %02h, want %02h",
                                                  m_axis_tdata, want.text));
                    if (m_axis_tuser[3] !== want.bvalid)
                        report_mismatch($sformatf("byte_valid %b, want %b",
                                                  m_axis_tuser[3], want.bvalid));
                    if (m_axis_tlast !== want.last)
                        report_mismatch($sformatf("end_of_text %b, want %b",
                                                  m_axis_tlast, want.last));
                end
            end
            if (stall_left > 0)
            begin
                stall_left--;
                m_axis_tready <= 1'b0;
            end
            else if (!calm && recv_idle_odds != 0 && $urandom_range(1, recv_idle_odds) == 1)
            begin
                stall_left = $urandom_range(1, 7) - 1;
                m_axis_tready <= 1'b0;
            end
            else
                m_axis_tready <= 1'b1;
        end
    end

    // Watchdog: a hung handshake or a missing result ends here.
    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("timeout after %0d cycles, %0d results still owed",
                 cycle_count, expected_text_q.size());
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // ------------------------------------------------------------------
    // Input side
    // ------------------------------------------------------------------
    // One byte transfer; valid stays high into the next call unless a gap is drawn.
    task automatic send_byte(input logic [7:0] b, input logic first);
        if (!calm && send_idle_odds != 0 && $urandom_range(1, send_idle_odds) == 1)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tuser  <= first;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        if (first || walk_phase != PH_DONE)
            bytes_walked++;
        predict_text_bytes(b, first);
    endtask

    // Sends the built file, first byte flagged, with idle rates drawn per file.
    task automatic send_file();
        int unsigned odds [3] = '{0, 3, 8};
        send_idle_odds = odds[$urandom_range(0, 2)];
        recv_idle_odds = odds[$urandom_range(0, 2)];
        foreach (file_bytes[i])
            send_byte(file_bytes[i], i == 0);
        file_bytes.delete();
        files_sent++;
    endtask

    task automatic push_string(input string s);
        for (int i = 0; i < s.len(); i++)
            file_bytes.push_back(s[i]);
    endtask

    // "ID3" v3 header; size bytes get random top bits, which the parser drops
    task automatic push_tag_header(input logic [27:0] size);
        push_string("ID3");
        file_bytes.push_back(8'h03);
        file_bytes.push_back(8'h00);
        file_bytes.push_back(8'h00);
        for (int g = 3; g >= 0; g--)
            file_bytes.push_back({1'($urandom_range(0, 1)), size[7*g +: 7]});
    endtask

    task automatic push_frame_header(input logic [31:0] id, input logic [31:0] len);
        for (int i = 3; i >= 0; i--)
            file_bytes.push_back(id[8*i +: 8]);
        for (int i = 3; i >= 0; i--)
            file_bytes.push_back(len[8*i +: 8]);
        file_bytes.push_back(8'($urandom_range(0, 255)));
        file_bytes.push_back(8'($urandom_range(0, 255)));
    endtask

    // Well-formed file with random frames; tag size mostly exact, sometimes
    // short (overlong last frame), long, or arbitrary; now and then cut short.
    task automatic push_random_file();
        int unsigned frame_count;
        int unsigned total;
        int unsigned tag_span;
        int unsigned lens [6];
        logic [31:0] ids [6];
        int unsigned pick;
        int unsigned cut;
        frame_count = $urandom_range(1, 6);
        total = 0;
        for (int i = 0; i < frame_count; i++)
        begin
            lens[i] = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40)
                                                   : $urandom_range(0, 12);
            pick = $urandom_range(0, 19);
            ids[i] = TEXT_IDS[$urandom_range(0, 5)];
            if (pick >= 15 && pick < 17)
                ids[i] = $urandom();
            else if (pick >= 17 && pick < 19)
                ids[i] = ids[i] & ~(32'hFF << (8 * $urandom_range(0, 3)));
            else if (pick == 19)
                ids[i] = ids[i] ^ (32'h1 << $urandom_range(0, 31));
            total += HDR_BYTES + lens[i];
        end
        case ($urandom_range(0, 9))
            0:       tag_span = $urandom_range(1, total);
            1:       tag_span = total + $urandom_range(1, 30);
            2:       tag_span = $urandom() & 32'h0FFF_FFFF;
            default: tag_span = total;
        endcase
        push_tag_header(28'(tag_span));
        for (int i = 0; i < frame_count; i++)
        begin
            push_frame_header(ids[i], lens[i]);
            for (int j = 0; j < lens[i]; j++)
            begin
                if (j == 0)
                    file_bytes.push_back(8'($urandom_range(0, 3)));
                else if ($urandom_range(0, 11) == 0)
                    file_bytes.push_back(8'h00);
                else
                    file_bytes.push_back(8'($urandom_range(1, 255)));
            end
        end
        repeat ($urandom_range(0, 3))
            file_bytes.push_back(8'($urandom_range(0, 255)));
        if ($urandom_range(0, 15) == 0)
        begin
            cut = $urandom_range(1, file_bytes.size() - 1);
            while (file_bytes.size() > cut)
                void'(file_bytes.pop_back());
        end
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    // All six text IDs: short text, empty frame, encoding-only frame, zero
    // inside the text, high byte values, zero as last payload byte, and
    // bytes past the tag that must be swallowed.
    task automatic test_text_ids();
        push_tag_header(28'd77);
        push_frame_header(ID_TIT2, 32'd3);
        file_bytes.push_back(8'h00);
        push_string("Hi");
        push_frame_header(ID_TPE1, 32'd0);
        push_frame_header(ID_TALB, 32'd1);
        file_bytes.push_back(8'h03);
        push_frame_header(ID_TYER, 32'd6);
        file_bytes.push_back(8'h03);
        push_string("19");
        file_bytes.push_back(8'h00);
        push_string("88");
        push_frame_header(ID_TCON, 32'd3);
        file_bytes.push_back(8'h01);
        file_bytes.push_back(8'hFF);
        file_bytes.push_back(8'h80);
        push_frame_header(ID_COMM, 32'd4);
        file_bytes.push_back(8'h00);
        file_bytes.push_back(8'h01);
        file_bytes.push_back(8'h7F);
        file_bytes.push_back(8'h00);
        push_string("TIT2");
        send_file();
    endtask

    // Tag size zero: a full text frame after the header is ignored.
    task automatic test_empty_tag();
        push_tag_header(28'd0);
        push_frame_header(ID_TIT2, 32'd2);
        file_bytes.push_back(8'h00);
        push_string("z");
        send_file();
    endtask

    // Unknown ID, an ID with a zero byte, then a frame running past the tag
    // size, which is still taken whole before the walk stops.
    task automatic test_overlong_and_unknown();
        push_tag_header(28'd25);
        push_frame_header(ID_TXXX, 32'd2);
        file_bytes.push_back(8'h00);
        push_string("q");
        push_frame_header(ID_TIT2 & 32'hFFFF_FF00, 32'd0);
        push_frame_header(ID_TIT2, 32'd4);
        file_bytes.push_back(8'h00);
        push_string("abc");
        push_frame_header(ID_TPE1, 32'd2);
        file_bytes.push_back(8'h00);
        push_string("n");
        send_file();
    endtask

    // Largest tag and frame sizes, file cut mid-text, restart in the middle
    // of a tag header, then a clean small file.
    task automatic test_truncation_restart();
        push_tag_header(28'hFFF_FFFF);
        push_frame_header(ID_TIT2, 32'hFFFF_FFFF);
        file_bytes.push_back(8'h00);
        push_string("xy");
        send_file();
        push_string("ID3");
        file_bytes.push_back(8'h03);
        send_file();
        push_tag_header(28'd11);
        push_frame_header(ID_TPE1, 32'd1);
        file_bytes.push_back(8'h01);
        send_file();
    endtask

    task automatic test_random_files();
        while (bytes_walked < RANDOM_GOAL)
        begin
            push_random_file();
            send_file();
        end
    endtask

    // Raw bytes with occasional restarts anywhere.
    task automatic test_noise();
        send_idle_odds = 4;
        recv_idle_odds = 4;
        repeat (NOISE_BYTES)
            send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 29) == 0);
    endtask

    // Back-to-back transfers on both sides.
    task automatic test_calm_tail();
        int unsigned goal;
        goal = bytes_walked + TAIL_BYTES;
        calm = 1'b1;
        while (bytes_walked < goal)
        begin
            push_random_file();
            send_file();
        end
    endtask

    initial
    begin
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = 8'h00;
        s_axis_tuser  = 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_text_ids();
        test_empty_tag();
        test_overlong_and_unknown();
        test_truncation_restart();
        test_random_files();
        test_noise();
        test_calm_tail();

        s_axis_tvalid <= 1'b0;
        while (expected_text_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("walked %0d file bytes over %0d files plus %0d noise bytes",
                 bytes_walked, files_sent, NOISE_BYTES);
        $display("compared %0d text transfers, %0d mismatches",
                 results_checked, mismatches);
        if (mismatches == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
